// File: design/skt_pkg.sv
// Shared constants, codes and types of the sorted key table.
`timescale 1ns / 1ps

package skt_pkg;

   localparam int Depth     = 16;
   localparam int KeyBits   = 16;
   localparam int ValueBits = 16;

   localparam int IdxBits    = $clog2(Depth);
   localparam int CntBits    = $clog2(Depth + 1);
   localparam int OpBits     = 3;
   localparam int StatusBits = 3;

   localparam logic [CntBits-1:0] FullCount = CntBits'(Depth);

   typedef enum logic [OpBits-1:0] {
      OpInsert    = 3'd0,
      OpDelete    = 3'd1,
      OpLookup    = 3'd2,
      OpIterReset = 3'd3,
      OpIterNext  = 3'd4
   } op_type;

   typedef enum logic [StatusBits-1:0] {
      StatusOk       = 3'd0,
      StatusFull     = 3'd1,
      StatusDup      = 3'd2,
      StatusMissing  = 3'd3,
      StatusPastEnd  = 3'd4
   } status_type;

   typedef struct packed {
      logic [KeyBits-1:0]   key;
      logic [ValueBits-1:0] value;
   } entry_type;

   typedef struct packed {
      logic               wr_en;
      logic [IdxBits-1:0] wr_addr;
      entry_type          wr_data;
      logic               rd_en;
      logic [IdxBits-1:0] rd_addr;
   } ram_req_type;

endpackage

// File: design/skt_if.sv
// Request and response channel interfaces of the sorted key table.
`timescale 1ns / 1ps

interface skt_req_if;
   logic                             valid;
   logic                             ready;
   logic [skt_pkg::OpBits-1:0]       operation;
   logic [skt_pkg::KeyBits-1:0]      key;
   logic [skt_pkg::ValueBits-1:0]    value;

   modport source (output valid, operation, key, value, input ready);
   modport sink (input valid, operation, key, value, output ready);
endinterface

interface skt_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [skt_pkg::StatusBits-1:0]   status;
   logic                             found;
   logic [skt_pkg::KeyBits-1:0]      key_out;
   logic [skt_pkg::ValueBits-1:0]    value_out;
   logic [skt_pkg::CntBits-1:0]      entry_count;
   logic                             table_full;

   modport source (output valid, status, found, key_out, value_out, entry_count, table_full,
                   input ready);
   modport sink (input valid, status, found, key_out, value_out, entry_count, table_full,
                 output ready);
endinterface

// File: design/skt_ram.sv
// Entry memory with one write port and one registered read port.
`timescale 1ns / 1ps

module skt_ram (
   input  logic                  clock,
   input  skt_pkg::ram_req_type  ram_req,
   output skt_pkg::entry_type    rd_data
);

   skt_pkg::entry_type entry_mem [skt_pkg::Depth];
   skt_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         entry_mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
      if (ram_req.rd_en) begin
         rd_data_ff <= entry_mem[ram_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/skt_ctrl.sv
// Operation sequencer: binary search, entry shifting, iterator and response register.
`timescale 1ns / 1ps

module skt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   skt_req_if.sink               req_ch,
   skt_rsp_if.source             rsp_ch,
   output skt_pkg::ram_req_type  ram_req,
   input  skt_pkg::entry_type    ram_rdata
);

   typedef enum logic [3:0] {
      StIdle,
      StDecode,
      StSearch,
      StProbe,
      StCheck,
      StShiftUp,
      StShiftDown,
      StIterWait,
      StFinish
   } state_type;

   state_type                        state_ff, state_in;
   skt_pkg::op_type                  op_ff, op_in;
   logic [skt_pkg::KeyBits-1:0]      key_ff, key_in;
   logic [skt_pkg::ValueBits-1:0]    value_ff, value_in;
   logic [skt_pkg::CntBits-1:0]      count_ff, count_in;
   logic [skt_pkg::CntBits-1:0]      iter_ff, iter_in;
   logic [skt_pkg::CntBits-1:0]      lo_ff, lo_in;
   logic [skt_pkg::CntBits-1:0]      hi_ff, hi_in;
   logic [skt_pkg::CntBits-1:0]      idx_ff, idx_in;
   logic                             pend_ff, pend_in;
   logic [skt_pkg::IdxBits-1:0]      pend_addr_ff, pend_addr_in;
   logic                             in_range_ff, in_range_in;
   skt_pkg::status_type              status_ff, status_in;
   logic                             found_ff, found_in;
   logic [skt_pkg::KeyBits-1:0]      kout_ff, kout_in;
   logic [skt_pkg::ValueBits-1:0]    vout_ff, vout_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   skt_pkg::status_type              rsp_status_ff, rsp_status_in;
   logic                             rsp_found_ff, rsp_found_in;
   logic [skt_pkg::KeyBits-1:0]      rsp_key_ff, rsp_key_in;
   logic [skt_pkg::ValueBits-1:0]    rsp_value_ff, rsp_value_in;
   logic [skt_pkg::CntBits-1:0]      rsp_count_ff, rsp_count_in;
   logic                             rsp_full_ff, rsp_full_in;

   logic [skt_pkg::CntBits:0]        mid_sum;
   logic [skt_pkg::CntBits-1:0]      mid;
   logic [skt_pkg::CntBits-1:0]      idx_dec;
   logic                             hit;

   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid     = mid_sum[skt_pkg::CntBits:1];
   assign idx_dec = idx_ff - 1'b1;
   assign hit     = in_range_ff && (ram_rdata.key == key_ff);

   assign req_ch.ready = (state_ff == StIdle);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      value_in      = value_ff;
      count_in      = count_ff;
      iter_in       = iter_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      idx_in        = idx_ff;
      pend_in       = pend_ff;
      pend_addr_in  = pend_addr_ff;
      in_range_in   = in_range_ff;
      status_in     = status_ff;
      found_in      = found_ff;
      kout_in       = kout_ff;
      vout_in       = vout_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_full_in   = rsp_full_ff;
      ram_req       = '0;

      case (state_ff)
         StIdle: begin
            if (req_ch.valid) begin
               op_in    = skt_pkg::op_type'(req_ch.operation);
               key_in   = req_ch.key;
               value_in = req_ch.value;
               state_in = StDecode;
            end
         end
         StDecode: begin
            status_in = skt_pkg::StatusOk;
            found_in  = 1'b0;
            kout_in   = '0;
            vout_in   = '0;
            lo_in     = '0;
            hi_in     = count_ff;
            pend_in   = 1'b0;
            case (op_ff)
               skt_pkg::OpInsert: begin
                  if (count_ff == skt_pkg::FullCount) begin
                     status_in = skt_pkg::StatusFull;
                     state_in  = StFinish;
                  end else begin
                     state_in = StSearch;
                  end
               end
               skt_pkg::OpDelete, skt_pkg::OpLookup: begin
                  state_in = StSearch;
               end
               skt_pkg::OpIterReset: begin
                  iter_in  = '0;
                  state_in = StFinish;
               end
               skt_pkg::OpIterNext: begin
                  if (iter_ff >= count_ff) begin
                     status_in = skt_pkg::StatusPastEnd;
                     state_in  = StFinish;
                  end else begin
                     ram_req.rd_en   = 1'b1;
                     ram_req.rd_addr = iter_ff[skt_pkg::IdxBits-1:0];
                     state_in        = StIterWait;
                  end
               end
               default: begin
                  state_in = StFinish;
               end
            endcase
         end
         StSearch: begin
            if (lo_ff < hi_ff) begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = mid[skt_pkg::IdxBits-1:0];
               idx_in          = mid;
               state_in        = StProbe;
            end else begin
               in_range_in = (lo_ff < count_ff);
               if (lo_ff < count_ff) begin
                  ram_req.rd_en   = 1'b1;
                  ram_req.rd_addr = lo_ff[skt_pkg::IdxBits-1:0];
               end
               state_in = StCheck;
            end
         end
         StProbe: begin
            if (ram_rdata.key < key_ff) begin
               lo_in = idx_ff + 1'b1;
            end else begin
               hi_in = idx_ff;
            end
            state_in = StSearch;
         end
         StCheck: begin
            case (op_ff)
               skt_pkg::OpInsert: begin
                  if (hit) begin
                     status_in = skt_pkg::StatusDup;
                     state_in  = StFinish;
                  end else begin
                     idx_in   = count_ff;
                     state_in = StShiftUp;
                  end
               end
               skt_pkg::OpDelete: begin
                  if (!hit) begin
                     status_in = skt_pkg::StatusMissing;
                     state_in  = StFinish;
                  end else begin
                     idx_in   = lo_ff + 1'b1;
                     state_in = StShiftDown;
                  end
               end
               skt_pkg::OpLookup: begin
                  if (!hit) begin
                     status_in = skt_pkg::StatusMissing;
                  end else begin
                     found_in = 1'b1;
                     kout_in  = ram_rdata.key;
                     vout_in  = ram_rdata.value;
                  end
                  state_in = StFinish;
               end
               default: begin
                  state_in = StFinish;
               end
            endcase
         end
         StShiftUp: begin
            if (pend_ff) begin
               ram_req.wr_en   = 1'b1;
               ram_req.wr_addr = pend_addr_ff;
               ram_req.wr_data = ram_rdata;
            end
            if (idx_ff > lo_ff) begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = idx_dec[skt_pkg::IdxBits-1:0];
               pend_addr_in    = idx_ff[skt_pkg::IdxBits-1:0];
               idx_in          = idx_dec;
               pend_in         = 1'b1;
            end else if (pend_ff) begin
               pend_in = 1'b0;
            end else begin
               ram_req.wr_en         = 1'b1;
               ram_req.wr_addr       = lo_ff[skt_pkg::IdxBits-1:0];
               ram_req.wr_data.key   = key_ff;
               ram_req.wr_data.value = value_ff;
               count_in              = count_ff + 1'b1;
               state_in              = StFinish;
            end
         end
         StShiftDown: begin
            if (pend_ff) begin
               ram_req.wr_en   = 1'b1;
               ram_req.wr_addr = pend_addr_ff;
               ram_req.wr_data = ram_rdata;
            end
            if (idx_ff < count_ff) begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = idx_ff[skt_pkg::IdxBits-1:0];
               pend_addr_in    = idx_dec[skt_pkg::IdxBits-1:0];
               idx_in          = idx_ff + 1'b1;
               pend_in         = 1'b1;
            end else if (pend_ff) begin
               pend_in = 1'b0;
            end else begin
               count_in = count_ff - 1'b1;
               state_in = StFinish;
            end
         end
         StIterWait: begin
            found_in = 1'b1;
            kout_in  = ram_rdata.key;
            vout_in  = ram_rdata.value;
            iter_in  = iter_ff + 1'b1;
            state_in = StFinish;
         end
         StFinish: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_found_in  = found_ff;
               rsp_key_in    = kout_ff;
               rsp_value_in  = vout_ff;
               rsp_count_in  = count_ff;
               rsp_full_in   = (count_ff == skt_pkg::FullCount);
               state_in      = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         count_ff     <= '0;
         iter_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         iter_ff      <= iter_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      key_ff        <= key_in;
      value_ff      <= value_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      idx_ff        <= idx_in;
      pend_addr_ff  <= pend_addr_in;
      in_range_ff   <= in_range_in;
      status_ff     <= status_in;
      found_ff      <= found_in;
      kout_ff       <= kout_in;
      vout_ff       <= vout_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_full_ff   <= rsp_full_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.found       = rsp_found_ff;
   assign rsp_ch.key_out     = rsp_key_ff;
   assign rsp_ch.value_out   = rsp_value_ff;
   assign rsp_ch.entry_count = rsp_count_ff;
   assign rsp_ch.table_full  = rsp_full_ff;

endmodule

// File: design/sorted_key_table_unit.sv
// Top level of the sorted key table: sequencer, entry memory and checks.
//
// The block keeps up to sixteen key/value entries in ascending key order.
// Each request transaction on req_ch carries one operation (insert, delete,
// lookup, iterator reset or iterator next) with a key and a value. Each
// request produces exactly one response transaction on rsp_ch with a status,
// the found flag, the returned key and value, the entry count and the full flag.
// Requests are processed one at a time by a sequencer around a single memory
// with a registered read port. Searches are binary searches that alternate
// between a probe read of the memory and narrowing of the search range. Insert
// then moves the entries at and above the found position up by one slot, and
// delete moves the entries above it down by one slot. The next request is
// accepted as soon as the previous result sits in the response register, even
// if the receiver has not taken it yet. When the receiver stalls, the response
// holds and the next result waits in the sequencer until the register frees
// up. Reset empties the table and rewinds the iterator; it needs no clearing
// pass.
`timescale 1ns / 1ps

module sorted_key_table_unit (
   input logic        clock,
   input logic        reset,
   skt_req_if.sink    req_ch,
   skt_rsp_if.source  rsp_ch
);

   skt_pkg::ram_req_type ram_req;
   skt_pkg::entry_type   ram_rdata;

   skt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .ram_req   (ram_req),
      .ram_rdata (ram_rdata)
   );

   skt_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (ram_rdata)
   );

   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.table_full == (rsp_ch.entry_count == skt_pkg::FullCount)))
      else $error("Full flag disagrees with entry count.");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.found) |-> (rsp_ch.status == skt_pkg::StatusOk))
      else $error("Returned entry with a failing status.");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.found) |-> (rsp_ch.key_out == '0 && rsp_ch.value_out == '0))
      else $error("Nonzero payload without a returned entry.");

   assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("Request accepted while an operation is in progress.");

   assert property (@(posedge clock) disable iff (reset)
      (ram_req.wr_en && ram_req.rd_en) |-> (ram_req.wr_addr != ram_req.rd_addr))
      else $error("Memory read and write collide on one entry.");

endmodule

// File: dv/sorted_key_table_unit_test.sv
// Self-checking testbench of the sorted key table with a scoreboard and random traffic.
`timescale 1ns / 1ps

module sorted_key_table_unit_test;
   import skt_pkg::*;

   localparam int RequestTarget = 1350;
   localparam int IdleLimit     = 3000;
   localparam int LongHold      = 400;
   localparam int PoolSize      = 24;

   typedef struct packed {
      status_type           status;
      logic                 found;
      logic [KeyBits-1:0]   key_out;
      logic [ValueBits-1:0] value_out;
      logic [CntBits-1:0]   entry_count;
      logic                 table_full;
   } table_result;

   // The scoreboard owns its own copy of the table and predicts each response.
   class table_scoreboard;
      logic [KeyBits-1:0]   keys[Depth];
      logic [ValueBits-1:0] values[Depth];
      int                   count;
      int                   iter_pos;
      table_result          expected_results[$];
      int                   errors;
      int                   requests;
      int                   checked;
      int                   full_events;
      int                   status_seen[5];

      function int first_not_below(logic [KeyBits-1:0] k);
         int i;
         for (i = 0; i < count; i++) begin
            if (keys[i] >= k) return i;
         end
         return count;
      endfunction

      function table_result apply_operation(logic [OpBits-1:0] op, logic [KeyBits-1:0] k,
                                            logic [ValueBits-1:0] v);
         table_result r;
         int          pos;
         int          i;
         r = '0;
         r.status = StatusOk;
         case (op)
            OpInsert: begin
               if (count >= Depth) begin
                  r.status = StatusFull;
               end else begin
                  pos = first_not_below(k);
                  if (pos < count && keys[pos] == k) begin
                     r.status = StatusDup;
                  end else begin
                     for (i = count; i > pos; i--) begin
                        keys[i] = keys[i-1];
                        values[i] = values[i-1];
                     end
                     keys[pos] = k;
                     values[pos] = v;
                     count++;
                  end
               end
            end
            OpDelete: begin
               pos = first_not_below(k);
               if (pos >= count || keys[pos] != k) begin
                  r.status = StatusMissing;
               end else begin
                  for (i = pos + 1; i < count; i++) begin
                     keys[i-1] = keys[i];
                     values[i-1] = values[i];
                  end
                  count--;
               end
            end
            OpLookup: begin
               pos = first_not_below(k);
               if (pos >= count || keys[pos] != k) begin
                  r.status = StatusMissing;
               end else begin
                  r.found = 1'b1;
                  r.key_out = keys[pos];
                  r.value_out = values[pos];
               end
            end
            OpIterReset: begin
               iter_pos = 0;
            end
            OpIterNext: begin
               if (iter_pos >= count) begin
                  r.status = StatusPastEnd;
               end else begin
                  r.found = 1'b1;
                  r.key_out = keys[iter_pos];
                  r.value_out = values[iter_pos];
                  iter_pos++;
               end
            end
            default: begin
            end
         endcase
         r.entry_count = CntBits'(count);
         r.table_full = (count == Depth);
         return r;
      endfunction

      function void note_request(logic [OpBits-1:0] op, logic [KeyBits-1:0] k,
                                 logic [ValueBits-1:0] v);
         table_result r;
         r = apply_operation(op, k, v);
         requests++;
         status_seen[r.status]++;
         if (r.table_full && op == OpInsert && r.status == StatusOk) full_events++;
         expected_results.push_back(r);
      endfunction

      function void compare_field(string name, logic [31:0] exp, logic [31:0] act);
         if (act !== exp) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, act);
            errors++;
         end
      endfunction

      function void check_response(table_result act);
         table_result exp;
         if (expected_results.size() == 0) begin
            $display("%0t: response with nothing expected, actual %h", $time, act);
            errors++;
            return;
         end
         exp = expected_results.pop_front();
         checked++;
         compare_field("status", 32'(exp.status), 32'(act.status));
         compare_field("found", 32'(exp.found), 32'(act.found));
         compare_field("key_out", 32'(exp.key_out), 32'(act.key_out));
         compare_field("value_out", 32'(exp.value_out), 32'(act.value_out));
         compare_field("entry_count", 32'(exp.entry_count), 32'(act.entry_count));
         compare_field("table_full", 32'(exp.table_full), 32'(act.table_full));
      endfunction
   endclass

   logic clock;
   logic reset;

   skt_req_if req_bus ();
   skt_rsp_if rsp_bus ();

   sorted_key_table_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   table_scoreboard      table_model = new();
   logic [KeyBits-1:0]   key_pool[PoolSize];
   bit                   quiet;
   int                   idle_cycles = 0;
   int                   items_sent;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      reset = 1'b1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      table_result act;
      if (!reset) begin
         act.status = status_type'(rsp_bus.status);
         act.found = rsp_bus.found;
         act.key_out = rsp_bus.key_out;
         act.value_out = rsp_bus.value_out;
         act.entry_count = rsp_bus.entry_count;
         act.table_full = rsp_bus.table_full;
         if (req_bus.valid && req_bus.ready) begin
            table_model.note_request(req_bus.operation, req_bus.key, req_bus.value);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            table_model.check_response(act);
         end
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= IdleLimit) begin
            $display("%0t: no transaction for %0d cycles, %0d responses outstanding",
                     $time, IdleLimit, table_model.expected_results.size());
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [KeyBits-1:0] pick_key();
      int r;
      r = $urandom_range(0, 9);
      if (r < 7) return key_pool[$urandom_range(0, PoolSize - 1)];
      if (r == 7 && table_model.count > 0) begin
         return table_model.keys[$urandom_range(0, table_model.count - 1)];
      end
      return KeyBits'($urandom_range(0, 65535));
   endfunction

   function automatic logic [KeyBits-1:0] pick_present_key();
      if (table_model.count > 0 && $urandom_range(0, 9) < 7) begin
         return table_model.keys[$urandom_range(0, table_model.count - 1)];
      end
      return pick_key();
   endfunction

   task automatic send_request(input logic [OpBits-1:0] op, input logic [KeyBits-1:0] k,
                               input logic [ValueBits-1:0] v);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.operation <= op;
      req_bus.key <= k;
      req_bus.value <= v;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic send_random(input logic [OpBits-1:0] op, input logic [KeyBits-1:0] k);
      send_request(op, k, ValueBits'($urandom_range(0, 65535)));
   endtask

   task automatic fill_table();
      int guard;
      guard = 0;
      while (table_model.count < Depth && guard < 40) begin
         send_random(OpInsert, pick_key());
         guard++;
      end
      send_random(OpInsert, KeyBits'($urandom_range(0, 65535)));
      if (table_model.count > 0) begin
         send_random(OpInsert, table_model.keys[$urandom_range(0, table_model.count - 1)]);
      end
      send_random(OpLookup, pick_present_key());
   endtask

   task automatic drain_table();
      int guard;
      int r;
      guard = 0;
      while (table_model.count > 0 && guard < 40) begin
         r = $urandom_range(0, 9);
         if (r < 8) send_random(OpDelete, pick_present_key());
         else if (r == 8) send_random(OpDelete, KeyBits'($urandom_range(0, 65535)));
         else send_random(OpLookup, pick_present_key());
         guard++;
      end
      send_random(OpDelete, pick_key());
      send_random(OpIterNext, pick_key());
   endtask

   task automatic walk_table();
      int steps;
      send_random(OpIterReset, pick_key());
      steps = table_model.count + $urandom_range(0, 2);
      repeat (steps) begin
         if ($urandom_range(0, 9) == 0) begin
            if ($urandom_range(0, 1)) send_random(OpInsert, pick_key());
            else send_random(OpDelete, pick_present_key());
         end else begin
            send_random(OpIterNext, pick_key());
         end
      end
   endtask

   task automatic mixed_traffic();
      int r;
      repeat ($urandom_range(10, 30)) begin
         r = $urandom_range(0, 99);
         if (r < 30) send_random(OpInsert, pick_key());
         else if (r < 50) send_random(OpDelete, pick_present_key());
         else if (r < 75) send_random(OpLookup, pick_present_key());
         else if (r < 90) send_random(OpIterNext, pick_key());
         else if (r < 97) send_random(OpIterReset, pick_key());
         else send_random(OpBits'($urandom_range(5, 7)), pick_key());
      end
   endtask

   task automatic noise_traffic();
      repeat ($urandom_range(5, 15)) begin
         send_random(OpBits'($urandom_range(0, 7)), KeyBits'($urandom_range(0, 65535)));
      end
   endtask

   initial begin
      int hold_done;
      int stall;
      hold_done = 0;
      rsp_bus.ready = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (hold_done == 0 && table_model.checked >= 300) begin
            rsp_bus.ready <= 1'b0;
            repeat (LongHold) @(negedge clock);
            hold_done = 1;
         end
         stall = pick_gap();
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
   end

   initial begin
      int i;
      int kind;
      req_bus.valid = 1'b0;
      req_bus.operation = '0;
      req_bus.key = '0;
      req_bus.value = '0;
      items_sent = 0;
      quiet = 1'b0;
      for (i = 0; i < PoolSize; i++) key_pool[i] = KeyBits'($urandom_range(0, 65535));
      key_pool[0] = '0;
      key_pool[1] = '1;
      wait (!reset);
      @(negedge clock);

      send_request(OpLookup, 16'h0000, 16'h0000);
      send_request(OpDelete, 16'hFFFF, 16'h0000);
      send_request(OpIterNext, 16'h0000, 16'h0000);
      send_request(OpInsert, 16'h8000, 16'hFFFF);
      send_request(OpInsert, 16'h0000, 16'h0000);
      send_request(OpInsert, 16'hFFFF, 16'hAAAA);
      send_request(OpInsert, 16'h7FFF, 16'h5555);
      send_request(OpInsert, 16'h8000, 16'h1234);
      send_request(OpLookup, 16'hFFFF, 16'h0000);
      send_request(OpLookup, 16'h0000, 16'h0000);
      send_request(OpLookup, 16'h8001, 16'h0000);
      send_request(OpIterReset, 16'h0000, 16'h0000);
      send_request(OpIterNext, 16'h0000, 16'h0000);
      send_request(OpIterNext, 16'h0000, 16'h0000);
      send_request(OpDelete, 16'h0000, 16'h0000);
      send_request(OpIterNext, 16'h0000, 16'h0000);
      send_request(OpIterNext, 16'h0000, 16'h0000);
      send_request(OpIterNext, 16'h0000, 16'h0000);
      send_request(OpDelete, 16'h8000, 16'h0000);
      send_request(OpDelete, 16'h8000, 16'h0000);
      send_request(OpBits'(5), 16'h1111, 16'h2222);
      send_request(OpBits'(6), 16'hFFFF, 16'hFFFF);
      send_request(OpBits'(7), 16'h0000, 16'h0000);

      while (items_sent < RequestTarget) begin
         quiet = ($urandom_range(0, 3) == 0);
         key_pool[$urandom_range(2, PoolSize - 1)] = KeyBits'($urandom_range(0, 65535));
         key_pool[$urandom_range(2, PoolSize - 1)] = KeyBits'($urandom_range(0, 65535));
         kind = $urandom_range(0, 9);
         if (kind < 2) fill_table();
         else if (kind < 4) drain_table();
         else if (kind < 6) walk_table();
         else if (kind < 9) mixed_traffic();
         else noise_traffic();
      end
      req_bus.valid <= 1'b0;
      quiet = 1'b0;

      while (table_model.expected_results.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);

      $display("Run sent %0d requests, checked %0d responses, filled the table %0d times.",
               table_model.requests, table_model.checked, table_model.full_events);
      $display("Statuses: ok %0d, full %0d, duplicate %0d, missing %0d, past end %0d.",
               table_model.status_seen[StatusOk], table_model.status_seen[StatusFull],
               table_model.status_seen[StatusDup], table_model.status_seen[StatusMissing],
               table_model.status_seen[StatusPastEnd]);
      if (table_model.errors == 0 && table_model.expected_results.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
